// ----- rtl/pit_pkg.sv -----
// Shared constants, codes and types of the peer inventory table.
package pit_pkg;

  localparam int PEER_SLOTS = 16;
  localparam int SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CNT_W = $clog2(PEER_SLOTS + 1);
  localparam int MAC_W = 48;
  localparam int TIME_W = 32;

  // operation codes
  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_EVICTED   = 3'd2;
  localparam logic [2:0] ST_READ_OK   = 3'd3;
  localparam logic [2:0] ST_READ_NONE = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic signed [7:0] signal;
    logic [3:0]        channel;
    logic [7:0]        length;
    logic              broadcast;
    logic [31:0]       frames;
    logic [TIME_W-1:0] origin_ms;
    logic [TIME_W-1:0] recent_ms;
  } entry_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [MAC_W-1:0]  source_mac;
    logic signed [7:0] signal_dbm;
    logic [3:0]        radio_channel;
    logic [7:0]        body_length;
    logic              is_broadcast;
    logic [TIME_W-1:0] now_ms;
    logic [3:0]        read_index;
  } item_t;

  typedef struct packed {
    logic  load;
    logic  rd_en;
    slot_t rd_addr;
    logic  commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctl_sts_t;

endpackage

// ----- rtl/pit_ifs.sv -----
// Request and response channel interfaces of the peer inventory table.
interface pit_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [47:0]       source_mac;
  logic signed [7:0] signal_dbm;
  logic [3:0]        radio_channel;
  logic [7:0]        body_length;
  logic              is_broadcast;
  logic [31:0]       now_ms;
  logic [3:0]        read_index;

  modport source (
    output valid, operation, source_mac, signal_dbm, radio_channel, body_length,
           is_broadcast, now_ms, read_index,
    input  ready
  );
  modport sink (
    input  valid, operation, source_mac, signal_dbm, radio_channel, body_length,
           is_broadcast, now_ms, read_index,
    output ready
  );
endinterface

interface pit_rsp_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [3:0]        slot;
  logic [4:0]        peer_count;
  logic [47:0]       entry_mac;
  logic signed [7:0] entry_signal;
  logic [3:0]        entry_channel;
  logic [7:0]        entry_length;
  logic              entry_broadcast;
  logic [31:0]       entry_frames;
  logic [31:0]       entry_first_seen;
  logic [31:0]       entry_last_seen;

  modport source (
    output valid, status, slot, peer_count, entry_mac, entry_signal, entry_channel,
           entry_length, entry_broadcast, entry_frames, entry_first_seen,
           entry_last_seen,
    input  ready
  );
  modport sink (
    input  valid, status, slot, peer_count, entry_mac, entry_signal, entry_channel,
           entry_length, entry_broadcast, entry_frames, entry_first_seen,
           entry_last_seen,
    output ready
  );
endinterface

// ----- rtl/pit_datapath.sv -----
// Datapath: slot memory, valid bits, scan trackers, update logic and result register.
module pit_datapath (
  input  logic              clk,
  input  logic              rst,
  input  pit_pkg::item_t    item,
  input  pit_pkg::ctl_cmd_t cmd,
  output pit_pkg::ctl_sts_t sts,
  pit_rsp_if.source         rsp
);
  import pit_pkg::*;

  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  entry_t                mem [PEER_SLOTS];
  entry_t                rdata;
  logic                  rd_vbit;
  logic                  chk_v;
  slot_t                 chk_idx;
  item_t                 item_q;
  logic [PEER_SLOTS-1:0] valid;
  logic [PEER_SLOTS-1:0] valid_next;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      count_next;

  logic                  sel_f;
  slot_t                 sel_slot;
  entry_t                sel_entry;
  logic                  free_f;
  slot_t                 free_slot;
  slot_t                 min_slot;
  logic [TIME_W-1:0]     min_time;
  logic [CNT_W-1:0]      seen_n;

  logic                  hit;
  logic                  wr_en;
  slot_t                 wr_slot;
  entry_t                wr_entry;
  logic [2:0]            res_status;
  slot_t                 res_slot;
  entry_t                res_entry;

  logic                  out_valid;
  logic [2:0]            out_status;
  logic [3:0]            out_slot;
  logic [4:0]            out_count;
  entry_t                out_entry;

  // observe matches the MAC, read matches the n-th valid entry
  always_comb begin
    if (item_q.operation == OP_OBSERVE) begin
      hit = rd_vbit && (rdata.mac == item_q.source_mac);
    end else begin
      hit = rd_vbit && (CMP_W'(seen_n) == CMP_W'(item_q.read_index));
    end
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_slot    = sel_slot;
    wr_entry   = sel_entry;
    res_status = ST_READ_NONE;
    res_slot   = '0;
    res_entry  = '0;
    count_next = count_q;
    valid_next = valid;
    case (item_q.operation)
      OP_OBSERVE: begin
        if (sel_f) begin
          res_status = ST_UPDATED;
        end else begin
          wr_slot             = free_f ? free_slot : min_slot;
          res_status          = free_f ? ST_NEW : ST_EVICTED;
          wr_entry.mac        = item_q.source_mac;
          wr_entry.frames     = '0;
          wr_entry.origin_ms  = item_q.now_ms;
          if (free_f) begin
            count_next = count_q + CNT_W'(1);
          end
        end
        wr_entry.signal    = item_q.signal_dbm;
        wr_entry.channel   = item_q.radio_channel;
        wr_entry.length    = item_q.body_length;
        wr_entry.broadcast = item_q.is_broadcast;
        wr_entry.recent_ms = item_q.now_ms;
        if (wr_entry.frames != '1) begin
          wr_entry.frames = wr_entry.frames + 32'd1;
        end
        wr_en               = cmd.commit;
        valid_next[wr_slot] = 1'b1;
        res_slot            = wr_slot;
        res_entry           = wr_entry;
      end
      OP_READ: begin
        if (sel_f) begin
          res_status = ST_READ_OK;
          res_slot   = sel_slot;
          res_entry  = sel_entry;
        end
      end
      OP_CLEAR: begin
        res_status = ST_CLEARED;
        valid_next = '0;
        count_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[cmd.rd_addr];
    end
    if (wr_en) begin
      mem[wr_slot] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      count_q   <= '0;
      chk_v     <= 1'b0;
      out_valid <= 1'b0;
      sel_f     <= 1'b0;
      free_f    <= 1'b0;
      seen_n    <= '0;
    end else begin
      chk_v <= cmd.rd_en;
      if (cmd.commit) begin
        valid   <= valid_next;
        count_q <= count_next;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        sel_f  <= 1'b0;
        free_f <= 1'b0;
        seen_n <= '0;
      end else if (chk_v) begin
        if (hit && !sel_f) begin
          sel_f <= 1'b1;
        end
        if (!rd_vbit && !free_f) begin
          free_f <= 1'b1;
        end
        if (rd_vbit) begin
          seen_n <= seen_n + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.rd_en) begin
      chk_idx <= cmd.rd_addr;
      rd_vbit <= valid[cmd.rd_addr];
    end
    if (chk_v) begin
      if (hit && !sel_f) begin
        sel_slot  <= chk_idx;
        sel_entry <= rdata;
      end
      if (!rd_vbit && !free_f) begin
        free_slot <= chk_idx;
      end
      // first slot seeds the minimum; ties keep the lower slot
      if (chk_idx == '0 || rdata.recent_ms < min_time) begin
        min_slot <= chk_idx;
        min_time <= rdata.recent_ms;
      end
    end
    if (cmd.commit) begin
      out_status <= res_status;
      out_slot   <= 4'(res_slot);
      out_count  <= 5'(count_next);
      out_entry  <= res_entry;
    end
  end

  assign sts.out_free = !out_valid || rsp.ready;

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.slot             = out_slot;
  assign rsp.peer_count       = out_count;
  assign rsp.entry_mac        = out_entry.mac;
  assign rsp.entry_signal     = out_entry.signal;
  assign rsp.entry_channel    = out_entry.channel;
  assign rsp.entry_length     = out_entry.length;
  assign rsp.entry_broadcast  = out_entry.broadcast;
  assign rsp.entry_frames     = out_entry.frames;
  assign rsp.entry_first_seen = out_entry.origin_ms;
  assign rsp.entry_last_seen  = out_entry.recent_ms;

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(count_q) == $countones(valid))
    else $error("peer count out of step with valid bits");

  a_commit_into_free_reg: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || rsp.ready))
    else $error("result committed over an untaken result");

  a_observe_leaves_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && item_q.operation == OP_OBSERVE |=> count_q != '0)
    else $error("observe left the table empty");

  a_no_scan_during_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !cmd.rd_en && !chk_v)
    else $error("commit while scan still in flight");

endmodule

// ----- rtl/pit_controller.sv -----
// Controller: sequences accept, slot scan, drain and result commit.
module pit_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [1:0]        req_op,
  output logic              req_ready,
  input  pit_pkg::ctl_sts_t sts,
  output pit_pkg::ctl_cmd_t cmd
);
  import pit_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  localparam slot_t LAST_SLOT = SLOT_W'(PEER_SLOTS - 1);

  state_t state;
  slot_t  addr;

  assign req_ready   = (state == S_IDLE);
  assign cmd.load    = req_valid && req_ready;
  assign cmd.rd_en   = (state == S_SCAN);
  assign cmd.rd_addr = addr;
  assign cmd.commit  = (state == S_FINISH) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      addr  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.load) begin
            addr <= '0;
            case (req_op)
              OP_OBSERVE, OP_READ: state <= S_SCAN;
              OP_CLEAR:            state <= S_FINISH;
              default:             state <= S_IDLE;  // drop undefined operation
            endcase
          end
        end
        S_SCAN: begin
          if (addr == LAST_SLOT) begin
            state <= S_DRAIN;
          end else begin
            addr <= addr + SLOT_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/peer_inventory_table_lru.sv -----
// Top level of the peer inventory table with least-recently-seen replacement.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    operation, source_mac, signal_dbm, radio_channel,
//                                body_length, is_broadcast, now_ms, read_index
//   rsp      out  valid/ready    status, slot, peer_count, entry_* fields
//
// Observe and read scan all PEER_SLOTS slots before the result: the slot memory's
// single read port walks one slot per cycle, then the drain and finish states follow.
// Clear skips the scan; an undefined operation is taken and gives no result.
// Reset clears the valid bits at once; there is no clearing pass.
// A stalled result holds in the output register while the next request is taken;
// that request then waits in its final cycle until the result is transferred.
module peer_inventory_table_lru (
  input logic     clk,
  input logic     rst,
  pit_req_if.sink   req,
  pit_rsp_if.source rsp
);
  import pit_pkg::*;

  item_t    item;
  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     ready;

  assign item.operation     = req.operation;
  assign item.source_mac    = req.source_mac;
  assign item.signal_dbm    = req.signal_dbm;
  assign item.radio_channel = req.radio_channel;
  assign item.body_length   = req.body_length;
  assign item.is_broadcast  = req.is_broadcast;
  assign item.now_ms        = req.now_ms;
  assign item.read_index    = req.read_index;
  assign req.ready          = ready;

  pit_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.operation),
    .req_ready (ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pit_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .cmd  (cmd),
    .sts  (sts),
    .rsp  (rsp)
  );

endmodule

// ----- tb/sv/tb_peer_inventory_table_lru.sv -----
// Self-checking testbench for the peer inventory table with LRU replacement.
module tb_peer_inventory_table_lru;
  import pit_pkg::*;

  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int MAC_POOL = 24;
  localparam int RANDOM_OPS = 420;
  localparam int FORCED_STALL_AT = 30;
  localparam int FORCED_STALL_LEN = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic [4:0] peer_count;
    entry_t     entry;
  } peer_result_t;

  typedef struct {
    item_t it;
    bit    drain_first;
  } pending_t;

  logic clk;
  logic rst;

  pit_req_if req_ch ();
  pit_rsp_if rsp_ch ();

  peer_inventory_table_lru dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the table
  logic   peer_valid [PEER_SLOTS] = '{default: 1'b0};
  entry_t peer_entry [PEER_SLOTS] = '{default: '0};

  pending_t     pending_ops [$];
  peer_result_t expected_results [$];

  int errors = 0;
  int results_issued = 0;
  int results_done = 0;
  int cnt_new = 0, cnt_updated = 0, cnt_evicted = 0;
  int cnt_read_ok = 0, cnt_read_none = 0, cnt_cleared = 0, cnt_ignored = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [47:0] rand_mac();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[47:0];
  endfunction

  function automatic item_t make_frame(input logic [1:0] op, input logic [47:0] mac,
                                       input logic [31:0] now);
    item_t it;
    it.operation     = op;
    it.source_mac    = mac;
    it.signal_dbm    = 8'($urandom_range(0, 255));
    it.radio_channel = 4'($urandom_range(0, 14));
    it.body_length   = 8'($urandom_range(0, 250));
    it.is_broadcast  = 1'($urandom_range(0, 1));
    it.now_ms        = now;
    it.read_index    = 4'($urandom_range(0, 15));
    return it;
  endfunction

  task automatic queue_op(input item_t it, input bit drain_first);
    pending_t p;
    p.it = it;
    p.drain_first = drain_first;
    pending_ops.push_back(p);
  endtask

  function automatic int live_peers();
    int n;
    n = 0;
    for (int i = 0; i < PEER_SLOTS; i++)
      if (peer_valid[i]) n++;
    return n;
  endfunction

  function automatic void wipe_peers();
    for (int i = 0; i < PEER_SLOTS; i++) begin
      peer_valid[i] = 1'b0;
      peer_entry[i] = '0;
    end
  endfunction

  // Apply one operation to the shadow table; returns 0 when no result follows.
  function automatic bit apply_peer_op(input item_t it, output peer_result_t r);
    int hit, free_slot, s, n, i;
    r = '0;
    hit = -1;
    free_slot = -1;
    case (it.operation)
      OP_OBSERVE: begin
        for (i = 0; i < PEER_SLOTS; i++) begin
          if (peer_valid[i] && peer_entry[i].mac == it.source_mac && hit < 0) hit = i;
          if (!peer_valid[i] && free_slot < 0) free_slot = i;
        end
        if (hit >= 0) begin
          s = hit;
          r.status = ST_UPDATED;
          cnt_updated++;
        end else begin
          if (free_slot >= 0) begin
            s = free_slot;
            r.status = ST_NEW;
            cnt_new++;
          end else begin
            // oldest last-seen wins, lowest slot on ties
            s = 0;
            for (i = 1; i < PEER_SLOTS; i++)
              if (peer_entry[i].recent_ms < peer_entry[s].recent_ms) s = i;
            r.status = ST_EVICTED;
            cnt_evicted++;
          end
          peer_valid[s] = 1'b1;
          peer_entry[s].mac = it.source_mac;
          peer_entry[s].frames = '0;
          peer_entry[s].origin_ms = it.now_ms;
        end
        peer_entry[s].signal    = it.signal_dbm;
        peer_entry[s].channel   = it.radio_channel;
        peer_entry[s].length    = it.body_length;
        peer_entry[s].broadcast = it.is_broadcast;
        peer_entry[s].recent_ms = it.now_ms;
        if (peer_entry[s].frames != 32'hFFFF_FFFF)
          peer_entry[s].frames = peer_entry[s].frames + 32'd1;
        r.slot = s[3:0];
        r.peer_count = 5'(live_peers());
        r.entry = peer_entry[s];
        return 1'b1;
      end
      OP_READ: begin
        r.status = ST_READ_NONE;
        r.peer_count = 5'(live_peers());
        n = 0;
        for (i = 0; i < PEER_SLOTS; i++) begin
          if (peer_valid[i]) begin
            if (n == it.read_index && r.status == ST_READ_NONE) begin
              r.status = ST_READ_OK;
              r.slot = i[3:0];
              r.entry = peer_entry[i];
            end
            n++;
          end
        end
        if (r.status == ST_READ_OK) cnt_read_ok++;
        else cnt_read_none++;
        return 1'b1;
      end
      OP_CLEAR: begin
        wipe_peers();
        r.status = ST_CLEARED;
        cnt_cleared++;
        return 1'b1;
      end
      default: begin
        cnt_ignored++;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Driver
  int       gap_left = 0;
  bit       tx_burst = 1'b0;
  pending_t next_op;
  peer_result_t next_result;

  function automatic int draw_gap(input bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 50) return 0;
    if (roll < 86) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid         <= 1'b0;
      req_ch.operation     <= OP_OBSERVE;
      req_ch.source_mac    <= '0;
      req_ch.signal_dbm    <= '0;
      req_ch.radio_channel <= '0;
      req_ch.body_length   <= '0;
      req_ch.is_broadcast  <= 1'b0;
      req_ch.now_ms        <= '0;
      req_ch.read_index    <= '0;
      gap_left = 0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold the offered item until the transfer
    end else if (gap_left > 0) begin
      gap_left--;
      req_ch.valid <= 1'b0;
    end else if (pending_ops.size() != 0 &&
                 !(pending_ops[0].drain_first && results_issued != results_done)) begin
      next_op = pending_ops.pop_front();
      req_ch.valid         <= 1'b1;
      req_ch.operation     <= next_op.it.operation;
      req_ch.source_mac    <= next_op.it.source_mac;
      req_ch.signal_dbm    <= next_op.it.signal_dbm;
      req_ch.radio_channel <= next_op.it.radio_channel;
      req_ch.body_length   <= next_op.it.body_length;
      req_ch.is_broadcast  <= next_op.it.is_broadcast;
      req_ch.now_ms        <= next_op.it.now_ms;
      req_ch.read_index    <= next_op.it.read_index;
      // predict now; the item stays offered until taken, so order holds
      if (apply_peer_op(next_op.it, next_result)) begin
        expected_results.push_back(next_result);
        results_issued++;
      end
      if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
      gap_left = draw_gap(tx_burst);
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Monitor and response backpressure
  int           stall_left = 0;
  int           ready_roll;
  bit           rx_burst = 1'b0;
  peer_result_t got_result;
  peer_result_t want_result;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_result.status           = rsp_ch.status;
        got_result.slot             = rsp_ch.slot;
        got_result.peer_count       = rsp_ch.peer_count;
        got_result.entry.mac        = rsp_ch.entry_mac;
        got_result.entry.signal     = rsp_ch.entry_signal;
        got_result.entry.channel    = rsp_ch.entry_channel;
        got_result.entry.length     = rsp_ch.entry_length;
        got_result.entry.broadcast  = rsp_ch.entry_broadcast;
        got_result.entry.frames     = rsp_ch.entry_frames;
        got_result.entry.origin_ms  = rsp_ch.entry_first_seen;
        got_result.entry.recent_ms  = rsp_ch.entry_last_seen;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer, status %0d", got_result.status);
          errors++;
        end else begin
          want_result = expected_results.pop_front();
          compare_field("status", want_result.status, got_result.status);
          compare_field("slot", want_result.slot, got_result.slot);
          compare_field("peer_count", want_result.peer_count, got_result.peer_count);
          compare_field("entry_mac", want_result.entry.mac, got_result.entry.mac);
          compare_field("entry_signal", want_result.entry.signal, got_result.entry.signal);
          compare_field("entry_channel", want_result.entry.channel,
                        got_result.entry.channel);
          compare_field("entry_length", want_result.entry.length, got_result.entry.length);
          compare_field("entry_broadcast", want_result.entry.broadcast,
                        got_result.entry.broadcast);
          compare_field("entry_frames", want_result.entry.frames, got_result.entry.frames);
          compare_field("entry_first_seen", want_result.entry.origin_ms,
                        got_result.entry.origin_ms);
          compare_field("entry_last_seen", want_result.entry.recent_ms,
                        got_result.entry.recent_ms);
        end
        // back up the table once so the request side stalls
        if (results_done + 1 == FORCED_STALL_AT) stall_left = FORCED_STALL_LEN;
        results_done <= results_done + 1;
      end
      if (stall_left == 0) begin
        if ($urandom_range(0, 59) == 0) rx_burst = !rx_burst;
        ready_roll = $urandom_range(0, 999);
        if (ready_roll < 3) stall_left = $urandom_range(60, 200);
        else if (!rx_burst && ready_roll < 40) stall_left = $urandom_range(10, 40);
        else if (!rx_burst && ready_roll < 300) stall_left = $urandom_range(1, 3);
      end
      rsp_ch.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  logic [47:0] mac_pool [MAC_POOL];
  logic [31:0] clock_ms;
  item_t       op_item;
  int          counted;
  int          roll;
  bit          first_random;

  initial begin
    rst = 1'b1;

    // empty table, field extremes, a hit, reads in and out of range
    op_item = make_frame(OP_READ, '0, '0);
    op_item.read_index = 4'd0;
    queue_op(op_item, 1'b0);
    op_item = make_frame(OP_OBSERVE, 48'h0, 32'h0);
    op_item.signal_dbm = -8'sd128;
    op_item.radio_channel = 4'd0;
    op_item.body_length = 8'd0;
    op_item.is_broadcast = 1'b0;
    queue_op(op_item, 1'b0);
    op_item = make_frame(OP_OBSERVE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    op_item.signal_dbm = 8'sd127;
    op_item.radio_channel = 4'd14;
    op_item.body_length = 8'd250;
    op_item.is_broadcast = 1'b1;
    queue_op(op_item, 1'b0);
    queue_op(make_frame(OP_OBSERVE, 48'h0, 32'd5), 1'b0);
    op_item = make_frame(OP_READ, '0, '0);
    op_item.read_index = 4'd0;
    queue_op(op_item, 1'b0);
    op_item.read_index = 4'd1;
    queue_op(op_item, 1'b0);
    op_item.read_index = 4'd15;
    queue_op(op_item, 1'b0);
    // fill the table with equal last-seen times to exercise tie breaking
    for (int k = 2; k < PEER_SLOTS; k++)
      queue_op(make_frame(OP_OBSERVE, 48'h0200_0000_0000 + k, 32'd100), 1'b0);
    queue_op(make_frame(OP_OBSERVE, 48'h0300_0000_0001, 32'd200), 1'b0);
    queue_op(make_frame(OP_OBSERVE, 48'h0300_0000_0002, 32'd201), 1'b0);
    op_item = make_frame(OP_READ, '0, '0);
    op_item.read_index = 4'd15;
    queue_op(op_item, 1'b0);
    queue_op(make_frame(OP_UNDEFINED, rand_mac(), $urandom), 1'b0);
    queue_op(make_frame(OP_CLEAR, rand_mac(), $urandom), 1'b0);
    op_item = make_frame(OP_READ, '0, '0);
    op_item.read_index = 4'd0;
    queue_op(op_item, 1'b0);

    // random part: a small MAC pool keeps hits and evictions frequent
    for (int k = 0; k < MAC_POOL; k++) mac_pool[k] = rand_mac();
    clock_ms = $urandom;
    counted = 0;
    first_random = 1'b1;
    while (counted < RANDOM_OPS) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) clock_ms = clock_ms + $urandom_range(0, 3);
      else if (roll < 65) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(1, 1000);
      roll = $urandom_range(0, 99);
      if (roll < 60)
        op_item = make_frame(OP_OBSERVE, mac_pool[$urandom_range(0, MAC_POOL - 1)], clock_ms);
      else if (roll < 68) op_item = make_frame(OP_OBSERVE, rand_mac(), clock_ms);
      else if (roll < 88) op_item = make_frame(OP_READ, rand_mac(), clock_ms);
      else if (roll < 90) op_item = make_frame(OP_CLEAR, rand_mac(), clock_ms);
      else if (roll < 93) op_item = make_frame(OP_UNDEFINED, rand_mac(), clock_ms);
      else
        op_item = make_frame(OP_OBSERVE, mac_pool[$urandom_range(0, MAC_POOL - 1)], clock_ms);
      if ($urandom_range(0, 39) == 0) mac_pool[$urandom_range(0, MAC_POOL - 1)] = rand_mac();
      queue_op(op_item, first_random || $urandom_range(0, 59) == 0);
      first_random = 1'b0;
      if (op_item.operation != OP_UNDEFINED) counted++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d new, %0d updated, %0d evicted peers; %0d reads found, %0d missed.",
             cnt_new, cnt_updated, cnt_evicted, cnt_read_ok, cnt_read_none);
    $display("Also %0d table clears and %0d undefined operations; %0d results checked.",
             cnt_cleared, cnt_ignored, results_done);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pit_pkg.sv
rtl/pit_ifs.sv
rtl/pit_datapath.sv
rtl/pit_controller.sv
rtl/peer_inventory_table_lru.sv
tb/sv/tb_peer_inventory_table_lru.sv
